// File: hdl/orq_pkg.sv
// Shared types and constants for the overwriting ring deque.
`timescale 1ns / 1ps

package orq_pkg;

	localparam int SLOT_BITS = 6;
	localparam int NUM_SLOTS = 64;
	localparam int WORD_BITS = 32;
	localparam int CAP_BITS  = 7;

	localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd50;
	localparam logic [CAP_BITS-1:0] CAP_MIN   = 7'd2;
	localparam logic [CAP_BITS-1:0] CAP_MAX   = 7'd64;

	typedef enum logic [2:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_BACK   = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_CLEAR      = 3'd4,
		CMD_READ_SLOT  = 3'd5,
		CMD_WRITE_SLOT = 3'd6
	} command_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_BAD_INDEX = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_READ = 4'b0100,
		S_RESP = 4'b1000
	} state_t;

	// Step strobes from the sequencer to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic read;
	} ctrl_cmd_t;

endpackage

// File: hdl/overwriting_ring_deque.sv
// A transaction is captured when it is accepted in the idle step, then passes the execute
// and read-back steps; its result is held in the respond step until the receiver takes it.
// A new transaction is accepted only once the previous result has been taken, so the
// sequencer handles one transaction at a time; an output stall holds the respond step.
// Reset clears pointers and count, loads a capacity of 50, and marks every slot as
// unwritten so that it reads as zero; no clearing pass is needed.
`timescale 1ns / 1ps

module overwriting_ring_deque (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [orq_pkg::CAP_BITS-1:0]   cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     command,
	input  logic [orq_pkg::WORD_BITS-1:0]  item_value,
	input  logic [orq_pkg::SLOT_BITS-1:0]  slot_index,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [orq_pkg::WORD_BITS-1:0]  front_value,
	output logic [orq_pkg::WORD_BITS-1:0]  back_value,
	output logic [orq_pkg::WORD_BITS-1:0]  read_data,
	output logic [orq_pkg::CAP_BITS-1:0]   element_count,
	output logic                           is_empty,
	output logic                           is_full,
	output logic                           overwrote,
	output logic [1:0]                     status
);

	orq_pkg::ctrl_cmd_t cmd;

	orq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	orq_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.command       (command),
		.item_value    (item_value),
		.slot_index    (slot_index),
		.front_value   (front_value),
		.back_value    (back_value),
		.read_data     (read_data),
		.element_count (element_count),
		.is_empty      (is_empty),
		.is_full       (is_full),
		.overwrote     (overwrote),
		.status        (status)
	);

`ifndef ASSERT_OFF
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> ##3 out_valid)
		else $error("result did not appear three cycles after an accepted transaction");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted while a result is pending");

	a_count_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (element_count <= orq_pkg::CAP_MAX)
			&& (is_empty == (element_count == '0)))
		else $error("element count out of range or empty flag inconsistent");

	a_bad_index_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == orq_pkg::ST_BAD_INDEX) |-> (read_data == '0))
		else $error("read data returned for an index beyond capacity");
`endif

endmodule

// File: hdl/orq_ctrl.sv
// Sequencer for the ring deque: accept, execute, read back, respond.
`timescale 1ns / 1ps

module orq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output orq_pkg::ctrl_cmd_t cmd
);

	orq_pkg::state_t state_q;
	orq_pkg::state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			orq_pkg::S_IDLE: begin
				if (in_valid) state_nxt = orq_pkg::S_EXEC;
			end
			orq_pkg::S_EXEC: begin
				state_nxt = orq_pkg::S_READ;
			end
			orq_pkg::S_READ: begin
				state_nxt = orq_pkg::S_RESP;
			end
			orq_pkg::S_RESP: begin
				if (!out_stall) state_nxt = orq_pkg::S_IDLE;
			end
			default: begin
				state_nxt = orq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= orq_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_stall  = (state_q != orq_pkg::S_IDLE);
	assign out_valid = (state_q == orq_pkg::S_RESP);
	assign cmd.load  = (state_q == orq_pkg::S_IDLE) && in_valid;
	assign cmd.exec  = (state_q == orq_pkg::S_EXEC);
	assign cmd.read  = (state_q == orq_pkg::S_READ);

endmodule

// File: hdl/orq_datapath.sv
// Slot memory, end pointers, count, capacity register and result registers.
`timescale 1ns / 1ps

module orq_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  orq_pkg::ctrl_cmd_t                  cmd,
	input  logic                                cfg_we,
	input  logic [orq_pkg::CAP_BITS-1:0]        cfg_data,
	input  logic [2:0]                          command,
	input  logic [orq_pkg::WORD_BITS-1:0]       item_value,
	input  logic [orq_pkg::SLOT_BITS-1:0]       slot_index,
	output logic [orq_pkg::WORD_BITS-1:0]       front_value,
	output logic [orq_pkg::WORD_BITS-1:0]       back_value,
	output logic [orq_pkg::WORD_BITS-1:0]       read_data,
	output logic [orq_pkg::CAP_BITS-1:0]        element_count,
	output logic                                is_empty,
	output logic                                is_full,
	output logic                                overwrote,
	output logic [1:0]                          status
);

	localparam int SB = orq_pkg::SLOT_BITS;
	localparam int CB = orq_pkg::CAP_BITS;
	localparam int WB = orq_pkg::WORD_BITS;

	logic [WB-1:0] mem [orq_pkg::NUM_SLOTS];
	logic [orq_pkg::NUM_SLOTS-1:0] valid_q;

	// Captured transaction.
	orq_pkg::command_t cmd_q;
	logic [WB-1:0]     value_q;
	logic [SB-1:0]     idx_q;

	logic [SB-1:0] head_q, tail_q;
	logic [CB-1:0] count_q, cap_q;

	logic [WB-1:0]     rd_a_q, rd_b_q, read_data_q;
	logic              over_q;
	orq_pkg::status_t  status_q;

	logic [SB-1:0]     head_nxt, tail_nxt, waddr;
	logic [CB-1:0]     count_nxt;
	logic              over_nxt, we;
	orq_pkg::status_t  status_nxt;

	logic [CB-1:0] head_inc, tail_inc, cap_m1;
	logic [SB-1:0] head_up, tail_up, head_dn, tail_dn;
	logic          empty, full, bad_idx;
	logic [CB-1:0] cap_clamped;

	assign head_inc = {1'b0, head_q} + CB'(1);
	assign tail_inc = {1'b0, tail_q} + CB'(1);
	assign cap_m1   = cap_q - CB'(1);
	assign head_up  = (head_inc == cap_q) ? '0 : head_inc[SB-1:0];
	assign tail_up  = (tail_inc == cap_q) ? '0 : tail_inc[SB-1:0];
	assign head_dn  = (head_q == '0) ? cap_m1[SB-1:0] : head_q - SB'(1);
	assign tail_dn  = (tail_q == '0) ? cap_m1[SB-1:0] : tail_q - SB'(1);
	assign empty    = (count_q == '0);
	assign full     = (count_q >= cap_q);
	assign bad_idx  = ({1'b0, idx_q} >= cap_q);

	always_comb begin
		if (cfg_data < orq_pkg::CAP_MIN) begin
			cap_clamped = orq_pkg::CAP_MIN;
		end else if (cfg_data > orq_pkg::CAP_MAX) begin
			cap_clamped = orq_pkg::CAP_MAX;
		end else begin
			cap_clamped = cfg_data;
		end
	end

	always_comb begin
		head_nxt   = head_q;
		tail_nxt   = tail_q;
		count_nxt  = count_q;
		over_nxt   = 1'b0;
		status_nxt = orq_pkg::ST_OK;
		we         = 1'b0;
		waddr      = tail_q;
		case (cmd_q)
			orq_pkg::CMD_PUSH_BACK: begin
				we = 1'b1;
				if (empty) begin
					head_nxt = tail_q;
				end else begin
					tail_nxt = tail_up;
					waddr    = tail_up;
					if (full) begin
						head_nxt = head_up;
						over_nxt = 1'b1;
					end
				end
				if (!full) count_nxt = count_q + CB'(1);
			end
			orq_pkg::CMD_PUSH_FRONT: begin
				we    = 1'b1;
				waddr = head_q;
				if (empty) begin
					tail_nxt = head_q;
				end else begin
					head_nxt = head_dn;
					waddr    = head_dn;
					if (full) begin
						tail_nxt = tail_dn;
						over_nxt = 1'b1;
					end
				end
				if (!full) count_nxt = count_q + CB'(1);
			end
			orq_pkg::CMD_POP_BACK: begin
				if (empty) begin
					status_nxt = orq_pkg::ST_POP_EMPTY;
				end else begin
					tail_nxt  = tail_dn;
					count_nxt = count_q - CB'(1);
				end
			end
			orq_pkg::CMD_POP_FRONT: begin
				if (empty) begin
					status_nxt = orq_pkg::ST_POP_EMPTY;
				end else begin
					head_nxt  = head_up;
					count_nxt = count_q - CB'(1);
				end
			end
			orq_pkg::CMD_CLEAR: begin
				head_nxt  = '0;
				tail_nxt  = '0;
				count_nxt = '0;
			end
			orq_pkg::CMD_READ_SLOT: begin
				if (bad_idx) status_nxt = orq_pkg::ST_BAD_INDEX;
			end
			orq_pkg::CMD_WRITE_SLOT: begin
				if (bad_idx) begin
					status_nxt = orq_pkg::ST_BAD_INDEX;
				end else begin
					we    = 1'b1;
					waddr = idx_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Control state: pointers, count, capacity and slot valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			cap_q   <= orq_pkg::CAP_RESET;
			valid_q <= '0;
		end else begin
			if (cfg_we) begin
				cap_q   <= cap_clamped;
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end else if (cmd.exec) begin
				head_q  <= head_nxt;
				tail_q  <= tail_nxt;
				count_q <= count_nxt;
			end
			if (cmd.exec && we) valid_q[waddr] <= 1'b1;
		end
	end

	// Slot memory: one write port and two registered read ports. A slot never
	// written reads as zero through its valid flag.
	always_ff @(posedge clk) begin
		if (cmd.exec && we) mem[waddr] <= value_q;
		if (cmd.exec) begin
			rd_a_q <= valid_q[idx_q] ? mem[idx_q] : '0;
		end else if (cmd.read) begin
			rd_a_q <= valid_q[head_q] ? mem[head_q] : '0;
		end
		if (cmd.read) rd_b_q <= valid_q[tail_q] ? mem[tail_q] : '0;
	end

	// Transaction capture and result registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q   <= orq_pkg::command_t'(command);
			value_q <= item_value;
			idx_q   <= slot_index;
		end
		if (cmd.exec) begin
			over_q   <= over_nxt;
			status_q <= status_nxt;
		end
		// During the read step rd_a_q still holds the raw slot read from the
		// execute step.
		if (cmd.read) begin
			read_data_q <= (cmd_q == orq_pkg::CMD_READ_SLOT && status_q == orq_pkg::ST_OK)
				? rd_a_q : '0;
		end
	end

	assign front_value   = empty ? '0 : rd_a_q;
	assign back_value    = empty ? '0 : rd_b_q;
	assign read_data     = read_data_q;
	assign element_count = count_q;
	assign is_empty      = empty;
	assign is_full       = (count_q == cap_q);
	assign overwrote     = over_q;
	assign status        = status_q;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the overwriting ring deque: a directed table, then random commands.
`timescale 1ns / 1ps

module tb;

	localparam int WORD_BITS = orq_pkg::WORD_BITS;
	localparam int CAP_BITS  = orq_pkg::CAP_BITS;
	localparam int SLOT_BITS = orq_pkg::SLOT_BITS;
	localparam int NUM_SLOTS = orq_pkg::NUM_SLOTS;

	localparam int STALL_LIMIT  = 2000;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int NUM_ROWS     = 28;
	localparam int NUM_PHASES   = 14;
	localparam int CHUNK        = 25;

	// Command code 7 is not decoded by the block and must leave it unchanged.
	localparam logic [2:0] CMD_UNUSED = 3'd7;

	typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } mix_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] front;
		logic [WORD_BITS-1:0] back;
		logic [WORD_BITS-1:0] rdata;
		logic [CAP_BITS-1:0]  count;
		logic                 empty;
		logic                 full;
		logic                 over;
		orq_pkg::status_t     st;
	} deque_snap_t;

	typedef struct packed {
		bit                   is_cfg;
		logic [CAP_BITS-1:0]  cap_val;
		logic [2:0]           cmd;
		logic [WORD_BITS-1:0] val;
		logic [SLOT_BITS-1:0] idx;
		bit                   typed;
		deque_snap_t          want;
	} dir_row_t;

	localparam deque_snap_t NO_SNAP   = '0;
	localparam deque_snap_t EMPTY_OK  = '{32'd0, 32'd0, 32'd0, 7'd0, 1'b1, 1'b0, 1'b0,
		orq_pkg::ST_OK};
	localparam deque_snap_t EMPTY_POP = '{32'd0, 32'd0, 32'd0, 7'd0, 1'b1, 1'b0, 1'b0,
		orq_pkg::ST_POP_EMPTY};
	localparam deque_snap_t EMPTY_BAD = '{32'd0, 32'd0, 32'd0, 7'd0, 1'b1, 1'b0, 1'b0,
		orq_pkg::ST_BAD_INDEX};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CAP_BITS-1:0]   cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [2:0]            command;
	logic [WORD_BITS-1:0]  item_value;
	logic [SLOT_BITS-1:0]  slot_index;
	logic                  out_valid;
	logic                  out_stall;
	logic [WORD_BITS-1:0]  front_value;
	logic [WORD_BITS-1:0]  back_value;
	logic [WORD_BITS-1:0]  read_data;
	logic [CAP_BITS-1:0]   element_count;
	logic                  is_empty;
	logic                  is_full;
	logic                  overwrote;
	logic [1:0]            status;

	overwriting_ring_deque u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.item_value    (item_value),
		.slot_index    (slot_index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.front_value   (front_value),
		.back_value    (back_value),
		.read_data     (read_data),
		.element_count (element_count),
		.is_empty      (is_empty),
		.is_full       (is_full),
		.overwrote     (overwrote),
		.status        (status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow copy of the deque kept by the testbench.
	logic [WORD_BITS-1:0] model_slots [NUM_SLOTS];
	int unsigned          model_head;
	int unsigned          model_tail;
	int unsigned          model_held;
	int unsigned          cap_now;

	deque_snap_t awaited_snaps [$];

	int  errors = 0;
	int  n_cmds, n_over, n_pop_empty, n_bad_index, n_settings, peak_count;
	bit  steady;
	bit  hold_req = 1'b0;

	dir_row_t dir_rows [NUM_ROWS] = '{
		'{1'b0, 7'd0, orq_pkg::CMD_POP_BACK,   32'd0,        6'd0,  1'b1, EMPTY_POP},
		'{1'b0, 7'd0, orq_pkg::CMD_POP_FRONT,  32'd0,        6'd0,  1'b1, EMPTY_POP},
		'{1'b0, 7'd0, orq_pkg::CMD_READ_SLOT,  32'd0,        6'd0,  1'b1, EMPTY_OK},
		'{1'b0, 7'd0, orq_pkg::CMD_READ_SLOT,  32'd0,        6'd63, 1'b1, EMPTY_BAD},
		'{1'b0, 7'd0, orq_pkg::CMD_WRITE_SLOT, 32'hDEADBEEF, 6'd50, 1'b1, EMPTY_BAD},
		'{1'b0, 7'd0, orq_pkg::CMD_PUSH_BACK,  32'hFFFFFFFF, 6'd0,  1'b1,
			'{32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 7'd1, 1'b0, 1'b0, 1'b0, orq_pkg::ST_OK}},
		'{1'b0, 7'd0, orq_pkg::CMD_PUSH_FRONT, 32'd0,        6'd0,  1'b0, NO_SNAP},
		'{1'b0, 7'd0, orq_pkg::CMD_PUSH_BACK,  32'h12345678, 6'd0,  1'b0, NO_SNAP},
		'{1'b0, 7'd0, orq_pkg::CMD_READ_SLOT,  32'd0,        6'd49, 1'b0, NO_SNAP},
		'{1'b0, 7'd0, orq_pkg::CMD_WRITE_SLOT, 32'hA5A5A5A5, 6'd49, 1'b0, NO_SNAP},
		'{1'b0, 7'd0, orq_pkg::CMD_POP_FRONT,  32'd0,        6'd0,  1'b0, NO_SNAP},
		'{1'b0, 7'd0, orq_pkg::CMD_POP_BACK,   32'd0,        6'd0,  1'b0, NO_SNAP},
		'{1'b0, 7'd0, orq_pkg::CMD_CLEAR,      32'd0,        6'd0,  1'b1, EMPTY_OK},
		'{1'b0, 7'd0, CMD_UNUSED,              32'hFFFFFFFF, 6'd63, 1'b1, EMPTY_OK},
		'{1'b0, 7'd0, orq_pkg::CMD_WRITE_SLOT, 32'h5555AAAA, 6'd0,  1'b1, EMPTY_OK},
		'{1'b0, 7'd0, orq_pkg::CMD_READ_SLOT,  32'd0,        6'd0,  1'b1,
			'{32'd0, 32'd0, 32'h5555AAAA, 7'd0, 1'b1, 1'b0, 1'b0, orq_pkg::ST_OK}},
		'{1'b1, 7'd0, orq_pkg::CMD_CLEAR,      32'd0,        6'd0,  1'b0, NO_SNAP},
		'{1'b0, 7'd0, orq_pkg::CMD_PUSH_BACK,  32'd1,        6'd0,  1'b0, NO_SNAP},
		'{1'b0, 7'd0, orq_pkg::CMD_PUSH_BACK,  32'd2,        6'd0,  1'b0, NO_SNAP},
		'{1'b0, 7'd0, orq_pkg::CMD_PUSH_BACK,  32'd3,        6'd0,  1'b1,
			'{32'd2, 32'd3, 32'd0, 7'd2, 1'b0, 1'b1, 1'b1, orq_pkg::ST_OK}},
		'{1'b0, 7'd0, orq_pkg::CMD_PUSH_FRONT, 32'd4,        6'd0,  1'b0, NO_SNAP},
		'{1'b0, 7'd0, orq_pkg::CMD_READ_SLOT,  32'd0,        6'd2,  1'b0, NO_SNAP},
		'{1'b0, 7'd0, orq_pkg::CMD_READ_SLOT,  32'd0,        6'd1,  1'b0, NO_SNAP},
		'{1'b1, 7'd127, orq_pkg::CMD_CLEAR,    32'd0,        6'd0,  1'b0, NO_SNAP},
		'{1'b0, 7'd0, orq_pkg::CMD_PUSH_FRONT, 32'd0,        6'd0,  1'b0, NO_SNAP},
		'{1'b0, 7'd0, orq_pkg::CMD_READ_SLOT,  32'd0,        6'd63, 1'b0, NO_SNAP},
		'{1'b0, 7'd0, orq_pkg::CMD_WRITE_SLOT, 32'hFFFFFFFF, 6'd63, 1'b0, NO_SNAP},
		'{1'b0, 7'd0, orq_pkg::CMD_POP_BACK,   32'd0,        6'd0,  1'b0, NO_SNAP}
	};

	logic [CAP_BITS-1:0] cap_plan [10] = '{7'd0, 7'd127, 7'd2, 7'd3, 7'd1, 7'd64, 7'd50,
		7'd5, 7'd7, 7'd2};

	function automatic deque_snap_t apply_command(input logic [2:0] cmd,
			input logic [WORD_BITS-1:0] val, input logic [SLOT_BITS-1:0] idx);
		deque_snap_t s;
		s = '0;
		s.st = orq_pkg::ST_OK;
		case (cmd)
			orq_pkg::CMD_PUSH_BACK: begin
				if (model_held == 0) begin
					model_head = model_tail;
				end else begin
					model_tail = (model_tail + 1) % cap_now;
					if (model_held >= cap_now) begin
						model_head = (model_head + 1) % cap_now;
						s.over = 1'b1;
					end
				end
				model_slots[model_tail] = val;
				if (model_held < cap_now) model_held++;
			end
			orq_pkg::CMD_PUSH_FRONT: begin
				if (model_held == 0) begin
					model_tail = model_head;
				end else begin
					model_head = (model_head + cap_now - 1) % cap_now;
					if (model_held >= cap_now) begin
						model_tail = (model_tail + cap_now - 1) % cap_now;
						s.over = 1'b1;
					end
				end
				model_slots[model_head] = val;
				if (model_held < cap_now) model_held++;
			end
			orq_pkg::CMD_POP_BACK: begin
				if (model_held == 0) begin
					s.st = orq_pkg::ST_POP_EMPTY;
				end else begin
					model_tail = (model_tail + cap_now - 1) % cap_now;
					model_held--;
				end
			end
			orq_pkg::CMD_POP_FRONT: begin
				if (model_held == 0) begin
					s.st = orq_pkg::ST_POP_EMPTY;
				end else begin
					model_head = (model_head + 1) % cap_now;
					model_held--;
				end
			end
			orq_pkg::CMD_CLEAR: begin
				model_head = 0;
				model_tail = 0;
				model_held = 0;
			end
			orq_pkg::CMD_READ_SLOT: begin
				if (idx >= cap_now) s.st = orq_pkg::ST_BAD_INDEX;
				else s.rdata = model_slots[idx];
			end
			orq_pkg::CMD_WRITE_SLOT: begin
				if (idx >= cap_now) s.st = orq_pkg::ST_BAD_INDEX;
				else model_slots[idx] = val;
			end
			default: begin
			end
		endcase
		s.empty = (model_held == 0);
		s.front = s.empty ? '0 : model_slots[model_head];
		s.back  = s.empty ? '0 : model_slots[model_tail];
		s.count = model_held[CAP_BITS-1:0];
		s.full  = (model_held == cap_now);
		n_cmds++;
		if (s.over) n_over++;
		if (s.st == orq_pkg::ST_POP_EMPTY) n_pop_empty++;
		if (s.st == orq_pkg::ST_BAD_INDEX) n_bad_index++;
		if (model_held > peak_count) peak_count = model_held;
		return s;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 2);
		if (r < 95) return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	task automatic flag_mismatch(input string what, input logic [WORD_BITS-1:0] got,
			input logic [WORD_BITS-1:0] want);
		errors++;
		$display("%0t ns: mismatch on %s, got %h, want %h", $time, what, got, want);
	endtask

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic offer(input logic [2:0] cmd, input logic [WORD_BITS-1:0] val,
			input logic [SLOT_BITS-1:0] idx, input bit typed, input deque_snap_t want);
		deque_snap_t calc;
		command    = cmd;
		item_value = val;
		slot_index = idx;
		in_valid   = 1'b1;
		do @(posedge clk); while (in_stall);
		calc = apply_command(cmd, val, idx);
		if (typed) calc = want;
		awaited_snaps = {awaited_snaps, calc};
		@(negedge clk);
	endtask

	task automatic sender_pause();
		if (!steady && $urandom_range(0, 2) == 0) begin
			in_valid = 1'b0;
			repeat (pick_gap()) @(negedge clk);
		end
	endtask

	// The capacity is only changed once every result has come back.
	task automatic write_capacity(input logic [CAP_BITS-1:0] v);
		in_valid = 1'b0;
		while (awaited_snaps.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_data = v;
		cfg_we   = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		if (v < orq_pkg::CAP_MIN) cap_now = 32'(orq_pkg::CAP_MIN);
		else if (v > orq_pkg::CAP_MAX) cap_now = 32'(orq_pkg::CAP_MAX);
		else cap_now = 32'(v);
		model_head = 0;
		model_tail = 0;
		model_held = 0;
		n_settings++;
	endtask

	initial begin : driver
		int                    r;
		int                    push_pct;
		int                    pop_pct;
		int                    n_items;
		mix_t                  mix;
		logic [2:0]            cmd;
		logic [WORD_BITS-1:0]  val;
		logic [SLOT_BITS-1:0]  idx;
		logic [CAP_BITS-1:0]   cap_val;

		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		command    = orq_pkg::CMD_PUSH_BACK;
		item_value = '0;
		slot_index = '0;
		steady     = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) model_slots[i] = '0;
		model_head = 0;
		model_tail = 0;
		model_held = 0;
		cap_now    = 32'(orq_pkg::CAP_RESET);
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				write_capacity(dir_rows[i].cap_val);
			end else begin
				offer(dir_rows[i].cmd, dir_rows[i].val, dir_rows[i].idx, dir_rows[i].typed,
					dir_rows[i].want);
				sender_pause();
			end
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			cap_val = (ph < 10) ? cap_plan[ph] : CAP_BITS'($urandom_range(2, 64));
			write_capacity(cap_val);
			n_items = (cap_now >= 48) ? 140 : 75;
			// The long receiver hold-off lands on the largest capacity, so the block
			// has to back up all the way to its input.
			if (cap_now == orq_pkg::CAP_MAX && ph == 5) hold_req = 1'b1;
			for (int k = 0; k < n_items; k++) begin
				if (k % CHUNK == 0) begin
					mix    = mix_t'($urandom_range(0, 2));
					steady = ($urandom_range(0, 4) == 0);
				end
				case (mix)
					MIX_FILL: begin
						push_pct = 75;
						pop_pct  = 10;
					end
					MIX_DRAIN: begin
						push_pct = 25;
						pop_pct  = 60;
					end
					default: begin
						push_pct = 45;
						pop_pct  = 40;
					end
				endcase
				r = $urandom_range(0, 99);
				if (r < push_pct) begin
					cmd = $urandom_range(0, 1) ? orq_pkg::CMD_PUSH_FRONT : orq_pkg::CMD_PUSH_BACK;
				end else if (r < push_pct + pop_pct) begin
					cmd = $urandom_range(0, 1) ? orq_pkg::CMD_POP_FRONT : orq_pkg::CMD_POP_BACK;
				end else begin
					r = $urandom_range(0, 24);
					if (r < 2) cmd = orq_pkg::CMD_CLEAR;
					else if (r < 12) cmd = orq_pkg::CMD_READ_SLOT;
					else if (r < 23) cmd = orq_pkg::CMD_WRITE_SLOT;
					else cmd = CMD_UNUSED;
				end
				r = $urandom_range(0, 9);
				if (r == 0) val = '0;
				else if (r == 1) val = '1;
				else val = $urandom;
				if ($urandom_range(0, 4) != 0) idx = SLOT_BITS'($urandom_range(0, cap_now - 1));
				else idx = SLOT_BITS'($urandom_range(0, NUM_SLOTS - 1));
				offer(cmd, val, idx, 1'b0, NO_SNAP);
				sender_pause();
			end
		end

		steady   = 1'b0;
		in_valid = 1'b0;
		while (awaited_snaps.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("covered %0d commands over %0d capacity settings, peak element count %0d",
			n_cmds, n_settings, peak_count);
		$display("pushes that overwrote: %0d, pops on empty: %0d, bad slot indexes: %0d",
			n_over, n_pop_empty, n_bad_index);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin : receiver
		int stall_left;
		bit hold_done;
		stall_left = 0;
		hold_done  = 1'b0;
		out_stall  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done  = 1'b1;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		deque_snap_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_snaps.size() == 0) begin
				flag_mismatch("result with nothing awaited", WORD_BITS'(element_count), '0);
			end else begin
				want = awaited_snaps[0];
				awaited_snaps.delete(0);
				if (front_value !== want.front) flag_mismatch("front_value", front_value, want.front);
				if (back_value !== want.back) flag_mismatch("back_value", back_value, want.back);
				if (read_data !== want.rdata) flag_mismatch("read_data", read_data, want.rdata);
				if (element_count !== want.count)
					flag_mismatch("element_count", WORD_BITS'(element_count),
						WORD_BITS'(want.count));
				if (is_empty !== want.empty)
					flag_mismatch("is_empty", WORD_BITS'(is_empty), WORD_BITS'(want.empty));
				if (is_full !== want.full)
					flag_mismatch("is_full", WORD_BITS'(is_full), WORD_BITS'(want.full));
				if (overwrote !== want.over)
					flag_mismatch("overwrote", WORD_BITS'(overwrote), WORD_BITS'(want.over));
				if (status !== want.st)
					flag_mismatch("status", WORD_BITS'(status), WORD_BITS'(want.st));
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
		end
		$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
			STALL_LIMIT, awaited_snaps.size());
		$display("simulation failed");
		$finish;
	end

endmodule
